// ----- rtl/rtty_fsk_modulator_assert.svh -----
// Assertion macros for the checker module of the RTTY FSK modulator.
`ifndef RTTY_FSK_MODULATOR_ASSERT_SVH
`define RTTY_FSK_MODULATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define RFM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RFM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rfm_pkg.sv -----
// Package with the constants, codes and helper functions of the RTTY FSK modulator.
`timescale 1ns / 1ps

package rfm_pkg;

  // Storage sizes.
  localparam int MSG_DEPTH   = 128;
  localparam int MSG_AW      = $clog2(MSG_DEPTH);
  localparam int SINE_POINTS = 1024;
  localparam int PHASE_W     = $clog2(SINE_POINTS);

  // Fixed field widths.
  localparam int STEP_W  = 10;
  localparam int SPS_W   = 16;
  localparam int CODE_W  = 5;
  localparam int FRAME_W = 8;
  localparam int DUTY_W  = 8;
  localparam int AMP_W   = 7;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam logic [DUTY_W-1:0] DUTY_MID = 8'd128;

  // Input item actions.
  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_START = 2'd1,
    ACT_TICK  = 2'd2
  } action_t;

  // Character classes held in the message store.
  typedef enum logic [1:0] {
    CLS_LETTERS  = 2'd0,
    CLS_FIGURES  = 2'd1,
    CLS_NEUTRAL  = 2'd2,
    CLS_UNMAPPED = 2'd3
  } char_class_t;

  // Configuration register indexes (word address).
  typedef enum logic [2:0] {
    REG_MARK_STEP   = 3'd0,
    REG_SPACE_STEP  = 3'd1,
    REG_SPS         = 3'd2,
    REG_FRAME_BITS  = 3'd3,
    REG_LSB_FIRST   = 3'd4,
    REG_LTRS_CODE   = 3'd5,
    REG_FIGS_CODE   = 3'd6
  } reg_index_t;

  // A frame is a start bit, the five code bits and two stop bits.
  function automatic logic [FRAME_W-1:0] frame_of(input logic [CODE_W-1:0] code);
    return {1'b0, code, 2'b11};
  endfunction

  // Frame length clamped to the range 1 to 8.
  function automatic logic [3:0] frame_len(input logic [3:0] fb);
    logic [3:0] r;
    if (fb == 4'd0) begin
      r = 4'd1;
    end else if (fb > 4'd8) begin
      r = 4'd8;
    end else begin
      r = fb;
    end
    return r;
  endfunction

endpackage

// ----- rtl/rfm_if.sv -----
// Valid/ready channel interfaces for the input and result transactions.
`timescale 1ns / 1ps

interface rfm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [6:0] entry_index;
  logic [4:0] char_code;
  logic [1:0] char_class;
  logic [7:0] message_length;

  modport source (output valid, action, entry_index, char_code, char_class,
                  message_length, input ready);
  modport sink (input valid, action, entry_index, char_code, char_class,
                message_length, output ready);
endinterface

interface rfm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] duty;
  logic       duty_updated;
  logic       busy_res;
  logic       char_sent;
  logic [6:0] sent_index;

  modport source (output valid, duty, duty_updated, busy_res, char_sent, sent_index,
                  input ready);
  modport sink (input valid, duty, duty_updated, busy_res, char_sent, sent_index,
                output ready);
endinterface

// ----- rtl/rfm_sine_rom.sv -----
// Half-sine ROM with a registered read port.
`timescale 1ns / 1ps

module rfm_sine_rom (
  input  logic                       clk,
  input  logic                       en,
  input  logic [rfm_pkg::PHASE_W-1:0] addr,
  output logic [rfm_pkg::AMP_W-1:0]   data
);
  import rfm_pkg::*;

  logic [AMP_W-1:0] sine_tab [SINE_POINTS];

  // Entries follow 127*sin(pi*i/S) in its rational approximation, rounded half up.
  for (genvar gi = 0; gi < SINE_POINTS; gi++) begin : g_tab
    localparam longint unsigned S = SINE_POINTS;
    localparam longint unsigned I = gi;
    localparam longint unsigned P = I * (S - I);
    localparam longint unsigned D = 5 * S * S - 4 * P;
    localparam longint unsigned V = (2 * 2032 * P + D) / (2 * D);
    assign sine_tab[gi] = V[AMP_W-1:0];
  end

  // The read register holds its value while the pipeline stalls.
  always_ff @(posedge clk) begin
    if (en) begin
      data <= sine_tab[addr];
    end
  end

endmodule

// ----- rtl/rtty_fsk_modulator.sv -----
// Top level of the RTTY FSK modulator: control, message store, phase accumulator, duty.
`timescale 1ns / 1ps
//
// Usage:
// - in_ch carries one transaction per action: write a message store entry, start
//   transmission, or a sample tick. Writes and starts are ignored while busy.
// - out_ch returns exactly one result transaction for every input transaction, in order:
//   the current PWM duty, whether this tick updated it, the busy flag and the
//   character that this tick consumed, if any.
// - The APB port sets tone steps, symbol length, frame length, bit order and shift
//   codes; write it only while no transaction is in flight.
// - From input acceptance, a result passes through one stage for the symbol and frame
//   control plus the sine ROM read, and one for the duty register.
// - Throughput is one transaction per cycle while out_ch does not stall; the registered
//   ROM read and the prefetched message store read make this possible.
// - While out_ch stalls, both stages hold and in_ch keeps accepting until the
//   first stage is full; nothing is dropped.
// - Reset (synchronous, active high) restores the default registers, sets the duty
//   to mid scale and leaves the block idle. The message store is not cleared and
//   needs no sweep, so the block accepts transactions right after reset.
//

module rtty_fsk_modulator (
  input  logic                        clk,
  input  logic                        rst,
  rfm_in_if.sink                      in_ch,
  rfm_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rfm_pkg::ADDR_W-1:0]  paddr,
  input  logic [rfm_pkg::DATA_W-1:0]  pwdata,
  output logic [rfm_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import rfm_pkg::*;

  // Status carried from the control stage to the duty stage.
  typedef struct packed {
    logic              updated;
    logic              busy;
    logic              sent;
    logic [MSG_AW-1:0] sent_index;
    logic              neg;
  } s1_info_t;

  // Configuration registers.
  logic [STEP_W-1:0] mark_step;
  logic [STEP_W-1:0] space_step;
  logic [SPS_W-1:0]  samples_per_symbol;
  logic [3:0]        frame_bits;
  logic              lsb_first;
  logic [CODE_W-1:0] letters_shift_code;
  logic [CODE_W-1:0] figures_shift_code;

  // Control state.
  logic [7:0]         message_count, message_count_next;
  logic [7:0]         read_position, read_position_next;
  logic               sending, sending_next;
  logic [SPS_W-1:0]   sample_countdown, sample_countdown_next;
  logic [3:0]         bit_position, bit_position_next;
  logic [FRAME_W-1:0] frame_shift, frame_shift_next;
  logic               figures_mode, figures_mode_next;
  logic [STEP_W-1:0]  phase_step, phase_step_next;
  logic [PHASE_W-1:0] phase, phase_next;
  logic               negative_half, negative_half_next;

  // Message store and its prefetched entry.
  logic [AMP_W-1:0] message_store [MSG_DEPTH];
  logic [AMP_W-1:0] store_q;
  logic             store_we;

  // Pipeline handshake.
  logic             accept;
  logic             s1_valid;
  s1_info_t         s1_info, s1_info_next;
  logic             s1_adv;
  logic             s2_free;
  logic             out_valid;
  logic [AMP_W-1:0] amp_q;
  logic [DUTY_W-1:0] duty, duty_next;
  logic             cfg_write;

  // APB access: always ready, writes land on the access cycle.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mark_step          <= STEP_W'(29);
      space_step         <= STEP_W'(23);
      samples_per_symbol <= SPS_W'(1333);
      frame_bits         <= 4'd8;
      lsb_first          <= 1'b0;
      letters_shift_code <= CODE_W'(31);
      figures_shift_code <= CODE_W'(27);
    end else if (cfg_write) begin
      case (reg_index_t'(paddr[4:2]))
        REG_MARK_STEP:  mark_step          <= pwdata[STEP_W-1:0];
        REG_SPACE_STEP: space_step         <= pwdata[STEP_W-1:0];
        REG_SPS:        samples_per_symbol <= pwdata[SPS_W-1:0];
        REG_FRAME_BITS: frame_bits         <= pwdata[3:0];
        REG_LSB_FIRST:  lsb_first          <= pwdata[0];
        REG_LTRS_CODE:  letters_shift_code <= pwdata[CODE_W-1:0];
        REG_FIGS_CODE:  figures_shift_code <= pwdata[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_index_t'(paddr[4:2]))
      REG_MARK_STEP:  prdata = DATA_W'(mark_step);
      REG_SPACE_STEP: prdata = DATA_W'(space_step);
      REG_SPS:        prdata = DATA_W'(samples_per_symbol);
      REG_FRAME_BITS: prdata = DATA_W'(frame_bits);
      REG_LSB_FIRST:  prdata = DATA_W'(lsb_first);
      REG_LTRS_CODE:  prdata = DATA_W'(letters_shift_code);
      REG_FIGS_CODE:  prdata = DATA_W'(figures_shift_code);
      default:        prdata = '0;
    endcase
  end

  // Two-stage valid/ready chain.
  assign s2_free     = !out_valid || out_ch.ready;
  assign s1_adv      = s1_valid && s2_free;
  assign in_ch.ready = !s1_valid || s2_free;
  assign accept      = in_ch.valid && in_ch.ready;

  // Next state for one accepted transaction.
  always_comb begin
    logic [SPS_W-1:0]   cd_dec;
    logic [3:0]         fl;
    logic [3:0]         bp;
    logic [2:0]         which;
    logic               stop;
    logic               take;
    logic [CODE_W-1:0]  e_code;
    char_class_t        e_class;
    logic [PHASE_W:0]   phase_sum;
    logic [3:0]         fl_m1;

    message_count_next    = message_count;
    read_position_next    = read_position;
    sending_next          = sending;
    sample_countdown_next = sample_countdown;
    bit_position_next     = bit_position;
    frame_shift_next      = frame_shift;
    figures_mode_next     = figures_mode;
    phase_step_next       = phase_step;
    phase_next            = phase;
    negative_half_next    = negative_half;
    store_we              = 1'b0;
    s1_info_next          = '0;

    cd_dec    = sample_countdown - SPS_W'(1);
    fl        = frame_len(frame_bits);
    fl_m1     = '0;
    bp        = bit_position + 4'd1;
    which     = '0;
    stop      = 1'b0;
    take      = 1'b1;
    e_code    = store_q[CODE_W-1:0];
    e_class   = char_class_t'(store_q[AMP_W-1:CODE_W]);
    phase_sum = '0;

    if (accept) begin
      case (action_t'(in_ch.action))
        ACT_WRITE: begin
          if (!sending && int'(in_ch.entry_index) < MSG_DEPTH) begin
            store_we = 1'b1;
          end
        end
        ACT_START: begin
          if (!sending) begin
            message_count_next    = (in_ch.message_length > 8'(MSG_DEPTH)) ?
                                    8'(MSG_DEPTH) : in_ch.message_length;
            read_position_next    = '0;
            bit_position_next     = 4'd8;
            sample_countdown_next = SPS_W'(1);
            sending_next          = 1'b1;
          end
        end
        ACT_TICK: begin
          if (sending) begin
            sample_countdown_next = cd_dec;
            // Symbol boundary: advance the bit and maybe load a new frame.
            if (cd_dec == '0) begin
              sample_countdown_next = samples_per_symbol;
              if (bp >= fl) begin
                bp = 4'd0;
                if (read_position >= message_count) begin
                  stop                  = 1'b1;
                  sending_next          = 1'b0;
                  message_count_next    = '0;
                  read_position_next    = '0;
                  bit_position_next     = '0;
                  sample_countdown_next = SPS_W'(1);
                end else begin
                  case (e_class)
                    CLS_LETTERS: begin
                      if (figures_mode) begin
                        figures_mode_next = 1'b0;
                        frame_shift_next  = frame_of(letters_shift_code);
                        take              = 1'b0;
                      end else begin
                        frame_shift_next = frame_of(e_code);
                      end
                    end
                    CLS_FIGURES: begin
                      if (!figures_mode) begin
                        figures_mode_next = 1'b1;
                        frame_shift_next  = frame_of(figures_shift_code);
                        take              = 1'b0;
                      end else begin
                        frame_shift_next = frame_of(e_code);
                      end
                    end
                    CLS_NEUTRAL: frame_shift_next = frame_of(e_code);
                    default: ;
                  endcase
                  if (take) begin
                    s1_info_next.sent       = 1'b1;
                    s1_info_next.sent_index = read_position[MSG_AW-1:0];
                    read_position_next      = read_position + 8'd1;
                  end
                end
              end
              if (!stop) begin
                bit_position_next = bp;
                fl_m1             = fl - 4'd1 - bp;
                which             = lsb_first ? bp[2:0] : fl_m1[2:0];
                phase_step_next   = frame_shift_next[which] ? mark_step : space_step;
              end
            end
            // Phase accumulator with a sign flip on each wrap.
            if (!stop) begin
              phase_sum = {1'b0, phase} + (PHASE_W + 1)'(phase_step_next);
              if (phase_sum >= (PHASE_W + 1)'(SINE_POINTS)) begin
                phase_sum          = phase_sum - (PHASE_W + 1)'(SINE_POINTS);
                negative_half_next = !negative_half;
              end
              phase_next           = phase_sum[PHASE_W-1:0];
              s1_info_next.updated = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    s1_info_next.busy = sending_next;
    s1_info_next.neg  = negative_half_next;
  end

  // Control state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      message_count    <= '0;
      read_position    <= '0;
      sending          <= 1'b0;
      sample_countdown <= SPS_W'(1);
      bit_position     <= '0;
      frame_shift      <= '0;
      figures_mode     <= 1'b0;
      phase_step       <= '0;
      phase            <= '0;
      negative_half    <= 1'b1;
    end else begin
      message_count    <= message_count_next;
      read_position    <= read_position_next;
      sending          <= sending_next;
      sample_countdown <= sample_countdown_next;
      bit_position     <= bit_position_next;
      frame_shift      <= frame_shift_next;
      figures_mode     <= figures_mode_next;
      phase_step       <= phase_step_next;
      phase            <= phase_next;
      negative_half    <= negative_half_next;
    end
  end

  // Message store; the entry at the next read position is always prefetched.
  always_ff @(posedge clk) begin
    if (store_we) begin
      message_store[in_ch.entry_index[MSG_AW-1:0]] <= {in_ch.char_class, in_ch.char_code};
    end
    store_q <= message_store[read_position_next[MSG_AW-1:0]];
  end

  // Sine amplitude for the new phase, read alongside the first stage.
  rfm_sine_rom u_rom (
    .clk  (clk),
    .en   (accept),
    .addr (phase_next),
    .data (amp_q)
  );

  // First stage valid and status.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info <= s1_info_next;
    end
  end

  // Duty value: mid scale plus or minus the sine amplitude.
  always_comb begin
    duty_next = duty;
    if (s1_info.updated) begin
      duty_next = s1_info.neg ? (DUTY_MID - DUTY_W'(amp_q)) : (DUTY_MID + DUTY_W'(amp_q));
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      duty      <= DUTY_MID;
    end else begin
      if (s1_adv) begin
        out_valid <= 1'b1;
        duty      <= duty_next;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_ch.duty_updated <= s1_info.updated;
      out_ch.busy_res     <= s1_info.busy;
      out_ch.char_sent    <= s1_info.sent;
      out_ch.sent_index   <= s1_info.sent_index;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.duty  = duty;

endmodule

// ----- rtl/rfm_checker.sv -----
// Port-level checker for the RTTY FSK modulator, bound to the top level.
`timescale 1ns / 1ps
`include "rtty_fsk_modulator_assert.svh"

module rfm_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] duty,
  input logic       duty_updated,
  input logic       busy_res,
  input logic       char_sent,
  input logic [6:0] sent_index
);

  // A stalled result holds its payload.
  `RFM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(duty) && $stable(sent_index) && $stable(char_sent), "stalled result changed")

  // A consumed character comes from a tick that kept transmitting.
  `RFM_ASSERT_IMPLY(a_sent_busy, clk, rst, out_valid && char_sent, busy_res && duty_updated, "character sent outside an active tick")

  // The index field is zero when no character was consumed.
  `RFM_ASSERT_IMPLY(a_idx_zero, clk, rst, out_valid && !char_sent, sent_index == 7'd0, "sent index not zero without a character")

  // A new duty value is only computed while transmitting.
  `RFM_ASSERT_IMPLY(a_upd_busy, clk, rst, out_valid && duty_updated, busy_res, "duty updated while idle")

endmodule

bind rtty_fsk_modulator rfm_checker u_rfm_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .duty         (out_ch.duty),
  .duty_updated (out_ch.duty_updated),
  .busy_res     (out_ch.busy_res),
  .char_sent    (out_ch.char_sent),
  .sent_index   (out_ch.sent_index)
);

// ----- tb/tb_rtty_fsk_modulator.sv -----
// Self-checking testbench for the RTTY FSK modulator: predicted duty, busy and character results.
`timescale 1ns / 1ps

module tb_rtty_fsk_modulator;
  import rfm_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 4;
  localparam int QUIET_LIMIT   = 3000;
  localparam int LONG_HOLD     = 400;
  localparam int PHASE_OPS     = 160;
  localparam int WRAP_TICKS    = 100;
  localparam logic [1:0] ACT_NOP   = 2'd3;
  localparam logic [7:0] MID_SCALE = 8'd128;

  // One input transaction.
  typedef struct packed {
    logic [1:0] act;
    logic [6:0] idx;
    logic [4:0] code;
    logic [1:0] cls;
    logic [7:0] len;
  } fsk_op_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0] duty;
    logic       upd;
    logic       busy;
    logic       sent;
    logic [6:0] sidx;
  } duty_res_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  rfm_in_if  in_ch();
  rfm_out_if out_ch();

  rtty_fsk_modulator u_top (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #HALF_PERIOD clk = ~clk;

  // Shadow copy of the configuration registers.
  logic [9:0]  c_mark, c_space;
  logic [15:0] c_sps;
  logic [3:0]  c_fbits;
  logic        c_lsb;
  logic [4:0]  c_ltrs, c_figs;

  // Shadow copy of the modulator state.
  logic [6:0]  m_store [MSG_DEPTH];
  bit          m_written [MSG_DEPTH];
  logic [6:0]  sine_rom [SINE_POINTS];
  int unsigned m_count, m_rd, m_bit, m_phase;
  logic [15:0] m_cd;
  logic [7:0]  m_frame;
  logic        m_active, m_figs, m_neg;
  logic [9:0]  m_step;
  logic [7:0]  m_duty;

  // Pending transactions, their predicted results, and results awaited from the block.
  fsk_op_t     pending_ops [$];
  duty_res_t   predicted_q [$];
  duty_res_t   duty_expect_q [$];
  fsk_op_t     cur_op;
  duty_res_t   cur_res;

  int unsigned ops_made = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count = 0;
  int unsigned gap_odds = 16;
  int unsigned src_gap = 0;
  int unsigned sink_hold = 0;
  logic        hold_req = 1'b0;

  // Predicts the result of one transaction and advances the shadow state.
  task automatic modulate_item(input fsk_op_t op, output duty_res_t res);
    int unsigned flen, nxt, sel, acc;
    logic [6:0]  ent;
    logic        took, halted;
    res = '0;
    took = 1'b0;
    halted = 1'b0;
    if (op.act == ACT_WRITE) begin
      // Store writes only land while idle.
      if (!m_active) begin
        m_store[op.idx] = {op.cls, op.code};
        m_written[op.idx] = 1'b1;
      end
    end else if (op.act == ACT_START) begin
      if (!m_active) begin
        m_count = (op.len > MSG_DEPTH) ? MSG_DEPTH : op.len;
        m_rd = 0;
        m_bit = 8;
        m_cd = 16'd1;
        m_active = 1'b1;
      end
    end else if (op.act == ACT_TICK && m_active) begin
      m_cd = m_cd - 16'd1;
      if (m_cd == 16'd0) begin
        flen = (c_fbits == 4'd0) ? 1 : ((c_fbits > 4'd8) ? 8 : c_fbits);
        nxt = m_bit + 1;
        m_cd = c_sps;
        if (nxt >= flen) begin
          nxt = 0;
          if (m_rd >= m_count) begin
            // Message done: back to idle with no duty update.
            m_active = 1'b0;
            m_count = 0;
            m_rd = 0;
            m_bit = 0;
            m_cd = 16'd1;
            halted = 1'b1;
          end else begin
            ent = m_store[m_rd % MSG_DEPTH];
            took = 1'b1;
            case (ent[6:5])
              CLS_LETTERS: begin
                if (m_figs) begin
                  m_figs = 1'b0;
                  m_frame = {1'b0, c_ltrs, 2'b11};
                  took = 1'b0;
                end else begin
                  m_frame = {1'b0, ent[4:0], 2'b11};
                end
              end
              CLS_FIGURES: begin
                if (!m_figs) begin
                  m_figs = 1'b1;
                  m_frame = {1'b0, c_figs, 2'b11};
                  took = 1'b0;
                end else begin
                  m_frame = {1'b0, ent[4:0], 2'b11};
                end
              end
              CLS_NEUTRAL: begin
                m_frame = {1'b0, ent[4:0], 2'b11};
              end
              default: begin
                // An unmapped character resends the previous frame.
              end
            endcase
            if (took) begin
              res.sent = 1'b1;
              res.sidx = m_rd[6:0];
              m_rd++;
            end
          end
        end
        if (!halted) begin
          m_bit = nxt;
          sel = c_lsb ? nxt : (flen - 1 - nxt);
          m_step = m_frame[sel[2:0]] ? c_mark : c_space;
        end
      end
      // Phase accumulator over the half-sine table, sign flips on each wrap.
      if (!halted) begin
        acc = m_phase + m_step;
        if (acc >= SINE_POINTS) begin
          acc = acc % SINE_POINTS;
          m_neg = ~m_neg;
        end
        m_phase = acc;
        m_duty = m_neg ? MID_SCALE - {1'b0, sine_rom[m_phase]}
                       : MID_SCALE + {1'b0, sine_rom[m_phase]};
        res.upd = 1'b1;
      end
    end
    res.duty = m_duty;
    res.busy = m_active;
  endtask

  // Queues one transaction together with its predicted result.
  task automatic push_op(input logic [1:0] act, input logic [6:0] idx, input logic [4:0] code,
                         input logic [1:0] cls, input logic [7:0] len);
    fsk_op_t   op;
    duty_res_t res;
    op.act = act;
    op.idx = idx;
    op.code = code;
    op.cls = cls;
    op.len = len;
    modulate_item(op, res);
    pending_ops.push_back(op);
    predicted_q.push_back(res);
    ops_made++;
  endtask

  task automatic push_tick();
    push_op(ACT_TICK, 7'($urandom), 5'($urandom), 2'($urandom), 8'($urandom));
  endtask

  task automatic push_write(input logic [6:0] idx);
    push_op(ACT_WRITE, idx, 5'($urandom_range(0, 31)), 2'($urandom_range(0, 3)),
            8'($urandom));
  endtask

  task automatic push_noise_start();
    push_op(ACT_START, 7'($urandom), 5'($urandom), 2'($urandom), 8'($urandom));
  endtask

  task automatic push_nop();
    push_op(ACT_NOP, 7'($urandom), 5'($urandom), 2'($urandom), 8'($urandom));
  endtask

  // Ticks until the shadow state says the message has gone out.
  task automatic run_to_idle();
    while (m_active) push_tick();
  endtask

  // Writes the message entries, starts, and ticks it out with some noise mixed in.
  task automatic send_message(input int unsigned len);
    int unsigned eff, pick, k;
    eff = (len > MSG_DEPTH) ? MSG_DEPTH : len;
    for (k = 0; k < eff; k++) begin
      if (!m_written[k] || $urandom_range(0, 2) != 0) push_write(7'(k));
    end
    push_op(ACT_START, 7'($urandom), 5'($urandom), 2'($urandom), 8'(len));
    while (m_active) begin
      pick = $urandom_range(0, 29);
      if (pick == 0) begin
        push_write(7'($urandom));
      end else if (pick == 1) begin
        push_noise_start();
      end else if (pick == 2) begin
        push_nop();
      end else begin
        push_tick();
      end
    end
  endtask

  // Mostly whole messages, the rest idle noise.
  task automatic random_traffic(input int unsigned n);
    int unsigned stop_at, pick;
    stop_at = ops_made + n;
    while (ops_made < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        send_message($urandom_range(0, 6));
      end else if (pick == 6) begin
        send_message($urandom_range(7, 20));
      end else if (pick == 7) begin
        push_write(7'($urandom));
      end else if (pick == 8) begin
        push_tick();
      end else begin
        push_nop();
      end
    end
  endtask

  // Holds off until every queued transaction has produced its result.
  task automatic wait_drained();
    while (results_seen < ops_made) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle.
  task automatic cfg_write(input reg_index_t r, input logic [15:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (r)
      REG_MARK_STEP:  c_mark = v[9:0];
      REG_SPACE_STEP: c_space = v[9:0];
      REG_SPS:        c_sps = v;
      REG_FRAME_BITS: c_fbits = v[3:0];
      REG_LSB_FIRST:  c_lsb = v[0];
      REG_LTRS_CODE:  c_ltrs = v[4:0];
      REG_FIGS_CODE:  c_figs = v[4:0];
      default: begin
      end
    endcase
  endtask

  task automatic apply_setup(input logic [9:0] mk, input logic [9:0] sp, input logic [15:0] sps,
                             input logic [3:0] fb, input logic lsb, input logic [4:0] lt,
                             input logic [4:0] fg);
    cfg_write(REG_MARK_STEP, 16'(mk));
    cfg_write(REG_SPACE_STEP, 16'(sp));
    cfg_write(REG_SPS, sps);
    cfg_write(REG_FRAME_BITS, 16'(fb));
    cfg_write(REG_LSB_FIRST, 16'(lsb));
    cfg_write(REG_LTRS_CODE, 16'(lt));
    cfg_write(REG_FIGS_CODE, 16'(fg));
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic cur_check(input duty_res_t want);
    check_field("duty", 32'(want.duty), 32'(out_ch.duty));
    check_field("duty_updated", 32'(want.upd), 32'(out_ch.duty_updated));
    check_field("busy_res", 32'(want.busy), 32'(out_ch.busy_res));
    check_field("char_sent", 32'(want.sent), 32'(out_ch.char_sent));
    check_field("sent_index", 32'(want.sidx), 32'(out_ch.sent_index));
  endtask

  // Input driver: presents queued transactions with random idle bursts.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        duty_expect_q.push_back(cur_res);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_ops.size() == 0) begin
          in_ch.valid <= 1'b0;
        end else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
          src_gap = $urandom_range(0, 18);
          in_ch.valid <= 1'b0;
        end else begin
          cur_op = pending_ops.pop_front();
          cur_res = predicted_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.action <= cur_op.act;
          in_ch.entry_index <= cur_op.idx;
          in_ch.char_code <= cur_op.code;
          in_ch.char_class <= cur_op.cls;
          in_ch.message_length <= cur_op.len;
        end
      end
    end
  end

  // Result monitor: compares each result transaction and drives ready with stalls.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (duty_expect_q.size() == 0) begin
          $error("result transaction with no expected result pending");
          fail_count++;
        end else begin
          cur_check(duty_expect_q.pop_front());
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        sink_hold = LONG_HOLD;
      end
      if (sink_hold > 0) begin
        sink_hold--;
        out_ch.ready <= 1'b0;
      end else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
        sink_hold = $urandom_range(0, 18);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run after a long stretch with no transaction on either side.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    longint unsigned prod, den;
    int unsigned     k;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_WRITE;
    in_ch.entry_index = '0;
    in_ch.char_code = '0;
    in_ch.char_class = '0;
    in_ch.message_length = '0;
    out_ch.ready = 1'b0;

    // Half-sine table from the rational sine approximation, rounded half up.
    for (k = 0; k < SINE_POINTS; k++) begin
      prod = longint'(k) * longint'(SINE_POINTS - k);
      den = 64'd5 * SINE_POINTS * SINE_POINTS - 64'd4 * prod;
      sine_rom[k] = 7'((64'd4064 * prod + den) / (64'd2 * den));
    end

    // Power-on state of registers and shadow state.
    c_mark = 10'd29;
    c_space = 10'd23;
    c_sps = 16'd1333;
    c_fbits = 4'd8;
    c_lsb = 1'b0;
    c_ltrs = 5'd31;
    c_figs = 5'd27;
    m_count = 0;
    m_rd = 0;
    m_bit = 0;
    m_phase = 0;
    m_cd = 16'd1;
    m_frame = 8'd0;
    m_active = 1'b0;
    m_figs = 1'b0;
    m_neg = 1'b1;
    m_step = 10'd0;
    m_duty = MID_SCALE;
    for (k = 0; k < MSG_DEPTH; k++) m_written[k] = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: idle tick, unused action, store extremes, all classes, zero-length message.
    push_tick();
    push_nop();
    push_op(ACT_WRITE, 7'd0, 5'd7, CLS_UNMAPPED, 8'd0);
    push_op(ACT_WRITE, 7'd127, 5'd0, CLS_UNMAPPED, 8'hFF);
    push_op(ACT_WRITE, 7'd1, 5'd31, CLS_LETTERS, 8'd0);
    push_op(ACT_WRITE, 7'd2, 5'd21, CLS_FIGURES, 8'd0);
    push_op(ACT_WRITE, 7'd3, 5'd4, CLS_NEUTRAL, 8'd0);
    push_op(ACT_WRITE, 7'd4, 5'd10, CLS_LETTERS, 8'd0);
    push_op(ACT_WRITE, 7'd5, 5'd0, CLS_UNMAPPED, 8'd0);
    push_op(ACT_START, 7'd0, 5'd0, CLS_LETTERS, 8'd0);
    push_tick();
    push_tick();
    wait_drained();

    // Directed: unmapped first, shift frames both ways, writes and starts while busy.
    apply_setup(10'd1023, 10'd0, 16'd1, 4'd3, 1'b0, 5'd31, 5'd27);
    push_op(ACT_START, 7'd0, 5'd0, CLS_LETTERS, 8'd6);
    push_tick();
    push_op(ACT_WRITE, 7'd0, 5'd31, CLS_FIGURES, 8'd0);
    push_op(ACT_START, 7'd0, 5'd0, CLS_LETTERS, 8'd200);
    push_nop();
    run_to_idle();
    wait_drained();

    // Random phases over a range of settings; each starts from a drained block.
    apply_setup(10'($urandom), 10'($urandom), 16'd1, 4'd8, 1'b0, 5'($urandom), 5'($urandom));
    gap_odds = 16;
    random_traffic(PHASE_OPS);
    // Long receiver stall while the sender keeps offering.
    hold_req = 1'b1;
    wait_drained();

    apply_setup(10'd0, 10'd1023, 16'd2, 4'd5, 1'b1, 5'd0, 5'd31);
    gap_odds = 8;
    random_traffic(PHASE_OPS);
    wait_drained();

    // Frame length zero acts as one; a full store with a clamped length.
    apply_setup(10'($urandom), 10'($urandom), 16'd1, 4'd0, 1'b0, 5'($urandom), 5'($urandom));
    gap_odds = 4;
    send_message($urandom_range(128, 255));
    random_traffic(PHASE_OPS);
    wait_drained();

    // Frame length above eight acts as eight; a stretch with no idling.
    apply_setup(10'($urandom), 10'($urandom), 16'd3, 4'd15, 1'b1, 5'($urandom),
                5'($urandom));
    gap_odds = 0;
    random_traffic(PHASE_OPS);
    wait_drained();

    apply_setup(10'd1023, 10'd0, 16'($urandom_range(1, 3)), 4'($urandom_range(1, 7)),
                1'($urandom), 5'd31, 5'd0);
    gap_odds = 16;
    random_traffic(PHASE_OPS);
    wait_drained();

    for (k = 0; k < 3; k++) begin
      apply_setup(10'($urandom), 10'($urandom), 16'($urandom_range(1, 4)),
                  4'($urandom_range(0, 15)), 1'($urandom), 5'($urandom), 5'($urandom));
      gap_odds = 12;
      random_traffic(PHASE_OPS);
      wait_drained();
    end

    // Last part: no idling on either side.
    apply_setup(10'($urandom), 10'($urandom), 16'($urandom_range(1, 2)),
                4'($urandom_range(0, 15)), 1'($urandom), 5'($urandom), 5'($urandom));
    gap_odds = 0;
    random_traffic(PHASE_OPS);
    wait_drained();

    // Zero symbol length: after the first frame loads, the countdown wraps past zero
    // and keeps counting, so the message stays in progress to the end of the run.
    apply_setup(10'($urandom), 10'($urandom), 16'd0, 4'd1, 1'b0, 5'($urandom),
                5'($urandom));
    push_op(ACT_START, 7'd0, 5'd0, CLS_LETTERS, 8'd1);
    for (k = 0; k < WRAP_TICKS; k++) push_tick();
    wait_drained();

    if (fail_count == 0 && duty_expect_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- rtty_fsk_modulator.f -----
+incdir+rtl
rtl/rfm_pkg.sv
rtl/rfm_if.sv
rtl/rfm_sine_rom.sv
rtl/rtty_fsk_modulator.sv
rtl/rfm_checker.sv
tb/tb_rtty_fsk_modulator.sv
